// ===== rtl/lspe_pkg.sv =====
// ----------------------------------------------------------------------------
// lspe_pkg
// Shared types and constants for the line sensor position estimator.
// ----------------------------------------------------------------------------
package lspe_pkg;

    localparam int POS_W   = 16;   // signed Q1.14 position
    localparam int QUO_W   = 15;   // quotient magnitude, at most 1.0 in Q1.14
    localparam int PIN_W   = 8;    // physical sensor pins
    localparam int CONF_W  = 2;
    localparam int STAMP_W = 32;

    localparam logic signed [POS_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [POS_W-1:0] NEG_ONE_Q14 = -16'sd16384;

    localparam logic [CONF_W-1:0] CONF_NONE  = 2'd0;
    localparam logic [CONF_W-1:0] CONF_ONE   = 2'd1;
    localparam logic [CONF_W-1:0] CONF_MULTI = 2'd2;

    localparam logic [1:0] REG_REVERSE  = 2'd0;
    localparam logic [1:0] REG_POLARITY = 2'd1;
    localparam logic [1:0] REG_ASSIGNED = 2'd2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } lspe_dir_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE,
        S_START,
        S_DIV,
        S_FIN
    } lspe_state_t;

    typedef struct packed {
        logic             reverse_order;
        logic             line_polarity;
        logic [PIN_W-1:0] assigned_mask;
    } lspe_cfg_t;

endpackage

// ===== rtl/line_sensor_position_estimator_top.sv =====
// ----------------------------------------------------------------------------
// line_sensor_position_estimator_top
// Weighted centroid of the active line sensor channels, Q1.14 output.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid / in_stall): pin_levels and sample_time of one poll.
//   Output beat (out_valid / out_stall): position, valid_res, confidence_code,
//   active_mask, level_mask and stamp_out for that poll, one beat per input.
//   Config (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 reverse_order,
//   1 line_polarity, 2 assigned_mask; cfg_ready is always high. Write only
//   while no beat is in flight.
// Timing: one poll at a time. The lanes capture at the input beat; the result
//   then passes the merge register, the divider start, 15 radix-2 steps of
//   one quotient bit each, the hand-off to the finish state and the output
//   register load. A new poll is not taken before the last one is through:
//   in_stall is low only in idle, which is entered once the result sits in
//   the output register.
// Stall: a stalled output beat holds; a finished result waits in the divider
//   until the output register frees up.
// Reset: registers return to reverse_order 0, line_polarity 1,
//   assigned_mask 63, no direction seen, previous position zero.
// ----------------------------------------------------------------------------
module line_sensor_position_estimator_top #(
    parameter int CHANNELS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lspe_pkg::PIN_W-1:0]   pin_levels,
    input  logic [lspe_pkg::STAMP_W-1:0] sample_time,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [lspe_pkg::POS_W-1:0] position,
    output logic                         valid_res,
    output logic [lspe_pkg::CONF_W-1:0]  confidence_code,
    output logic [lspe_pkg::PIN_W-1:0]   active_mask,
    output logic [lspe_pkg::PIN_W-1:0]   level_mask,
    output logic [lspe_pkg::STAMP_W-1:0] stamp_out,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [lspe_pkg::PIN_W-1:0]   cfg_data
);
    import lspe_pkg::*;

    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int MAG_W = $clog2(CHANNELS * CHANNELS / 4 + 1);
    localparam int DEN_W = $clog2((CHANNELS - 1) * CHANNELS + 1);
    localparam int NUM_W = MAG_W + QUO_W + 1;
    localparam int DVS_W = DEN_W + 1;

    // ---------------- configuration ----------------
    lspe_cfg_t cfg_reg;
    lspe_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_REVERSE:  cfg_next.reverse_order = cfg_data[0];
                REG_POLARITY: cfg_next.line_polarity = cfg_data[0];
                REG_ASSIGNED: cfg_next.assigned_mask = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reverse_order <= 1'b0;
            cfg_reg.line_polarity <= 1'b1;
            cfg_reg.assigned_mask <= 8'd63;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- control ----------------
    lspe_state_t state_reg;
    lspe_state_t state_next;
    logic        in_beat;
    logic        merge_load;
    logic        div_start;
    logic        div_done;
    logic        out_load;
    logic        out_free;
    logic        out_valid_reg;
    logic        out_valid_next;

    assign in_beat  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        merge_load = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                merge_load = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- lanes ----------------
    logic [CHANNELS-1:0] level_vec;
    logic [CHANNELS-1:0] act_vec;
    logic [STAMP_W-1:0]  stamp_hold_reg;

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            stamp_hold_reg <= sample_time;
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        localparam int PF = i;
        localparam int PR = CHANNELS - 1 - i;
        logic pin_fwd;
        logic pin_rev;
        logic asg_fwd;
        logic asg_rev;

        // pins beyond the physical eight read as unassigned
        if (PF < PIN_W)
        begin : g_fwd
            assign pin_fwd = pin_levels[PF];
            assign asg_fwd = cfg_reg.assigned_mask[PF];
        end
        else
        begin : g_fwd_none
            assign pin_fwd = 1'b0;
            assign asg_fwd = 1'b0;
        end

        if (PR < PIN_W)
        begin : g_rev
            assign pin_rev = pin_levels[PR];
            assign asg_rev = cfg_reg.assigned_mask[PR];
        end
        else
        begin : g_rev_none
            assign pin_rev = 1'b0;
            assign asg_rev = 1'b0;
        end

        lspe_lane u_lane (
            .clk     (clk),
            .load    (in_beat),
            .cfg     (cfg_reg),
            .pin_fwd (pin_fwd),
            .pin_rev (pin_rev),
            .asg_fwd (asg_fwd),
            .asg_rev (asg_rev),
            .level   (level_vec[i]),
            .active  (act_vec[i])
        );
    end

    // drop channels above the eighth from the masks
    logic [PIN_W-1:0] act8;
    logic [PIN_W-1:0] lev8;

    for (genvar k = 0; k < PIN_W; k++)
    begin : g_mask
        if (k < CHANNELS)
        begin : g_on
            assign act8[k] = act_vec[k];
            assign lev8[k] = level_vec[k];
        end
        else
        begin : g_off
            assign act8[k] = 1'b0;
            assign lev8[k] = 1'b0;
        end
    end

    // ---------------- merge ----------------
    logic [CNT_W-1:0] cnt;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;

    lspe_merge #(
        .CHANNELS (CHANNELS),
        .CNT_W    (CNT_W),
        .MAG_W    (MAG_W),
        .DEN_W    (DEN_W)
    ) u_merge (
        .clk  (clk),
        .load (merge_load),
        .act  (act_vec),
        .cnt  (cnt),
        .neg  (neg),
        .mag  (mag),
        .den  (den)
    );

    // ---------------- divide ----------------
    // round to nearest: q = floor((2*|wsum|*2^14 + den) / (2*den))
    logic [NUM_W-1:0] div_num;
    logic [DVS_W-1:0] div_dvs;
    logic [QUO_W-1:0] div_quo;

    assign div_num = {1'b0, mag, {QUO_W{1'b0}}} + NUM_W'(den);
    assign div_dvs = {den, 1'b0};

    lspe_div #(
        .NUM_W (NUM_W),
        .DVS_W (DVS_W),
        .QUO_W (QUO_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .dvs   (div_dvs),
        .done  (div_done),
        .quo   (div_quo)
    );

    // ---------------- finish and output ----------------
    lspe_dir_t               last_dir_reg;
    lspe_dir_t               last_dir_next;
    logic signed [POS_W-1:0] prev_pos_reg;
    logic signed [POS_W-1:0] prev_pos_next;
    logic signed [POS_W-1:0] q_ext;
    logic signed [POS_W-1:0] pos_fin;
    logic                    valid_fin;
    logic [CONF_W-1:0]       conf_fin;

    logic signed [POS_W-1:0] position_reg;
    logic                    valid_res_reg;
    logic [CONF_W-1:0]       conf_reg;
    logic [PIN_W-1:0]        act_out_reg;
    logic [PIN_W-1:0]        lev_out_reg;
    logic [STAMP_W-1:0]      stamp_out_reg;

    always_comb
    begin
        q_ext         = {1'b0, div_quo};
        pos_fin       = neg ? -q_ext : q_ext;
        valid_fin     = 1'b0;
        conf_fin      = CONF_NONE;
        last_dir_next = last_dir_reg;
        if (cnt != '0)
        begin
            // junction: all channels on, keep the position but mark it unusable
            if (cnt != CNT_W'(CHANNELS))
            begin
                valid_fin = 1'b1;
                conf_fin  = (cnt == CNT_W'(1)) ? CONF_ONE : CONF_MULTI;
                if (pos_fin != '0)
                begin
                    last_dir_next = pos_fin[POS_W-1] ? DIR_NEG : DIR_POS;
                end
            end
        end
        else
        begin
            unique case (last_dir_reg)
                DIR_POS: pos_fin = ONE_Q14;
                DIR_NEG: pos_fin = NEG_ONE_Q14;
                default: pos_fin = prev_pos_reg;
            endcase
        end
        prev_pos_next = out_load ? pos_fin : prev_pos_reg;
        if (!out_load)
        begin
            last_dir_next = last_dir_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_dir_reg  <= DIR_NONE;
            prev_pos_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            last_dir_reg  <= last_dir_next;
            prev_pos_reg  <= prev_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            position_reg  <= pos_fin;
            valid_res_reg <= valid_fin;
            conf_reg      <= conf_fin;
            act_out_reg   <= act8;
            lev_out_reg   <= lev8;
            stamp_out_reg <= stamp_hold_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign position        = position_reg;
    assign valid_res       = valid_res_reg;
    assign confidence_code = conf_reg;
    assign active_mask     = act_out_reg;
    assign level_mask      = lev_out_reg;
    assign stamp_out       = stamp_out_reg;

    // ---------------- assertions ----------------
    a_valid_conf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> confidence_code != CONF_NONE)
        else $error("usable position reported with zero confidence");

    a_invalid_conf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> confidence_code == CONF_NONE)
        else $error("unusable position reported with nonzero confidence");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position >= NEG_ONE_Q14 && position <= ONE_Q14)
        else $error("position outside +/-1.0");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

endmodule

// ===== rtl/lspe_lane.sv =====
// ----------------------------------------------------------------------------
// lspe_lane
// One sensor channel: pin reorder, assignment mask and polarity detect.
// ----------------------------------------------------------------------------
module lspe_lane (
    input  logic              clk,
    input  logic              load,
    input  lspe_pkg::lspe_cfg_t cfg,
    input  logic              pin_fwd,
    input  logic              pin_rev,
    input  logic              asg_fwd,
    input  logic              asg_rev,
    output logic              level,
    output logic              active
);
    import lspe_pkg::*;

    logic pin_sel;
    logic asg_sel;
    logic level_reg;
    logic level_next;
    logic active_reg;
    logic active_next;

    always_comb
    begin
        pin_sel     = cfg.reverse_order ? pin_rev : pin_fwd;
        asg_sel     = cfg.reverse_order ? asg_rev : asg_fwd;
        level_next  = asg_sel & pin_sel;
        active_next = asg_sel & (pin_sel == cfg.line_polarity);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg  <= level_next;
            active_reg <= active_next;
        end
    end

    assign level  = level_reg;
    assign active = active_reg;

endmodule

// ===== rtl/lspe_merge.sv =====
// ----------------------------------------------------------------------------
// lspe_merge
// Combine lane results: active count, weight sum magnitude and sign, divisor.
// ----------------------------------------------------------------------------
module lspe_merge #(
    parameter int CHANNELS = 8,
    parameter int CNT_W    = 4,
    parameter int MAG_W    = 5,
    parameter int DEN_W    = 6
) (
    input  logic                clk,
    input  logic                load,
    input  logic [CHANNELS-1:0] act,
    output logic [CNT_W-1:0]    cnt,
    output logic                neg,
    output logic [MAG_W-1:0]    mag,
    output logic [DEN_W-1:0]    den
);
    import lspe_pkg::*;

    localparam int SUM_W = MAG_W + 1;

    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [MAG_W-1:0]        mag_reg;
    logic [MAG_W-1:0]        mag_next;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        den_next;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_abs;

    // lane i weighs (CHANNELS-1-2i), scaled by 1/(CHANNELS-1) in the divider
    always_comb
    begin
        cnt_next = '0;
        sum      = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (act[i])
            begin
                cnt_next = cnt_next + CNT_W'(1);
                sum      = sum + SUM_W'(CHANNELS - 1 - 2 * i);
            end
        end
        neg_next = sum[SUM_W-1];
        sum_abs  = neg_next ? -sum : sum;
        mag_next = sum_abs[MAG_W-1:0];
        den_next = DEN_W'(CHANNELS - 1) * DEN_W'(cnt_next);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cnt_reg <= cnt_next;
            neg_reg <= neg_next;
            mag_reg <= mag_next;
            den_reg <= den_next;
        end
    end

    assign cnt = cnt_reg;
    assign neg = neg_reg;
    assign mag = mag_reg;
    assign den = den_reg;

endmodule

// ===== rtl/lspe_div.sv =====
// ----------------------------------------------------------------------------
// lspe_div
// Radix-2 restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module lspe_div #(
    parameter int NUM_W = 24,
    parameter int DVS_W = 9,
    parameter int QUO_W = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DVS_W-1:0] dvs,
    output logic             done,
    output logic [QUO_W-1:0] quo
);
    import lspe_pkg::*;

    localparam int REM_W = NUM_W + DVS_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [REM_W-1:0] dsh_reg;
    logic [REM_W-1:0] dsh_next;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic             ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        ge        = (rem_reg >= dsh_reg);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W - 1);
            rem_next  = REM_W'(num);
            // the quotient fits QUO_W bits, so start with the divisor at the top bit
            dsh_next  = REM_W'(dvs) << (QUO_W - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== dv/tb_line_sensor_position_estimator_top.sv =====
// ----------------------------------------------------------------------------
// tb_line_sensor_position_estimator_top
// Self-checking bench for the eight-channel line position estimator. A
// directed table covers reset behavior, lost-line steering, junctions,
// unassigned pins, mirrored order and inverted polarity. Random phases with
// varied register settings follow. Every accepted poll runs through a local
// centroid predictor, and each output beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_line_sensor_position_estimator_top;

    import lspe_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int LIMIT_CYCLES      = 400000;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int END_SETTLE_CYCLES = 40;
    localparam int NUM_PHASES        = 9;
    localparam int PHASE_POLLS       = 50;
    localparam int DIRECTED_COUNT    = 24;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    valid_res;
        logic [CONF_W-1:0]       confidence_code;
        logic [PIN_W-1:0]        active_mask;
        logic [PIN_W-1:0]        level_mask;
        logic [STAMP_W-1:0]      stamp_out;
    } centroid_t;

    typedef enum logic {
        ROW_POLL,
        ROW_WRITE
    } row_kind_t;

    // w_* fields hold the typed-in result, used only when typed is set
    typedef struct packed {
        row_kind_t               kind;
        logic [1:0]              reg_idx;
        logic [PIN_W-1:0]        value;
        logic [STAMP_W-1:0]      stamp;
        logic                    typed;
        logic signed [POS_W-1:0] w_pos;
        logic                    w_valid;
        logic [CONF_W-1:0]       w_conf;
        logic [PIN_W-1:0]        w_act;
        logic [PIN_W-1:0]        w_lev;
    } row_t;

    localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // reset settings: pins 0..5 assigned, high means line
        '{ROW_POLL,  '0, 8'h00, 32'h0,         1'b1, 16'sd0,      1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'h01, 32'hFFFF_FFFF, 1'b1, ONE_Q14,     1'b1, CONF_ONE,   8'h01, 8'h01},
        '{ROW_POLL,  '0, 8'h00, 32'h1,         1'b1, ONE_Q14,     1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'hC0, 32'h8000_0000, 1'b1, ONE_Q14,     1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'h3F, 32'h7FFF_FFFF, 1'b0, 16'sd0,      1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'h0C, 32'h1234_5678, 1'b0, 16'sd0,      1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'h18, 32'h100,       1'b1, 16'sd0,      1'b1, CONF_MULTI, 8'h18, 8'h18},
        '{ROW_POLL,  '0, 8'h00, 32'h101,       1'b1, ONE_Q14,     1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_WRITE, REG_ASSIGNED, 8'hFF, 32'h0, 1'b0, 16'sd0,    1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'h80, 32'hAAAA_AAAA, 1'b1, NEG_ONE_Q14, 1'b1, CONF_ONE,   8'h80, 8'h80},
        '{ROW_POLL,  '0, 8'hFF, 32'h5555_5555, 1'b1, 16'sd0,      1'b0, CONF_NONE,  8'hFF, 8'hFF},
        '{ROW_POLL,  '0, 8'h00, 32'h200,       1'b1, NEG_ONE_Q14, 1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'hFE, 32'h201,       1'b0, 16'sd0,      1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'h55, 32'h202,       1'b0, 16'sd0,      1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_WRITE, REG_REVERSE, 8'h01, 32'h0, 1'b0, 16'sd0,     1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'h01, 32'h300,       1'b1, NEG_ONE_Q14, 1'b1, CONF_ONE,   8'h80, 8'h80},
        '{ROW_POLL,  '0, 8'h00, 32'h301,       1'b1, NEG_ONE_Q14, 1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_WRITE, REG_POLARITY, 8'h00, 32'h0, 1'b0, 16'sd0,    1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'hFF, 32'h400,       1'b1, NEG_ONE_Q14, 1'b0, CONF_NONE,  8'h00, 8'hFF},
        '{ROW_POLL,  '0, 8'h00, 32'h401,       1'b1, 16'sd0,      1'b0, CONF_NONE,  8'hFF, 8'h00},
        '{ROW_POLL,  '0, 8'hFE, 32'h402,       1'b1, NEG_ONE_Q14, 1'b1, CONF_ONE,   8'h80, 8'h7F},
        '{ROW_POLL,  '0, 8'h7F, 32'h403,       1'b1, ONE_Q14,     1'b1, CONF_ONE,   8'h01, 8'hFE},
        '{ROW_WRITE, REG_ASSIGNED, 8'h00, 32'h0, 1'b0, 16'sd0,    1'b0, CONF_NONE,  8'h00, 8'h00},
        '{ROW_POLL,  '0, 8'hAA, 32'h500,       1'b1, ONE_Q14,     1'b0, CONF_NONE,  8'h00, 8'h00}
    };

    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    in_valid        = 1'b0;
    logic                    in_stall;
    logic [PIN_W-1:0]        pin_levels      = '0;
    logic [STAMP_W-1:0]      sample_time     = '0;
    logic                    out_valid;
    logic                    out_stall       = 1'b0;
    logic signed [POS_W-1:0] position;
    logic                    valid_res;
    logic [CONF_W-1:0]       confidence_code;
    logic [PIN_W-1:0]        active_mask;
    logic [PIN_W-1:0]        level_mask;
    logic [STAMP_W-1:0]      stamp_out;
    logic                    cfg_valid       = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index       = '0;
    logic [PIN_W-1:0]        cfg_data        = '0;

    // predictor copy of the registers and state, reset values
    logic                    cur_reverse     = 1'b0;
    logic                    cur_polarity    = 1'b1;
    logic [PIN_W-1:0]        cur_assigned    = 8'h3F;
    lspe_dir_t               dir_state       = DIR_NONE;
    logic signed [POS_W-1:0] prev_pos_state  = '0;

    centroid_t               centroid_q [$];
    int                      error_count     = 0;
    bit                      idle_on         = 1'b1;
    bit                      hold_off_req    = 1'b0;

    line_sensor_position_estimator_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pin_levels      (pin_levels),
        .sample_time     (sample_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .position        (position),
        .valid_res       (valid_res),
        .confidence_code (confidence_code),
        .active_mask     (active_mask),
        .level_mask      (level_mask),
        .stamp_out       (stamp_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("tb_line_sensor_position_estimator_top: errors");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
        error_count++;
    endtask

    function automatic centroid_t predict_centroid(input logic [PIN_W-1:0] pins,
                                                   input logic [STAMP_W-1:0] stamp);
        centroid_t r;
        int        i;
        int        p;
        int        count;
        int        wsum;
        int        num;
        int        den;
        int        mag;
        int        quo;
        r     = '0;
        count = 0;
        wsum  = 0;
        for (i = 0; i < PIN_W; i++)
        begin
            p = cur_reverse ? PIN_W - 1 - i : i;
            if (cur_assigned[p])
            begin
                r.level_mask[i] = pins[p];
                if (pins[p] == cur_polarity)
                begin
                    r.active_mask[i] = 1'b1;
                    count++;
                    wsum += PIN_W - 1 - 2 * i;
                end
            end
        end
        if (count > 0)
        begin
            // round half away from zero
            num = wsum * 16384;
            den = (PIN_W - 1) * count;
            mag = (num < 0) ? -num : num;
            quo = (2 * mag + den) / (2 * den);
            r.position = POS_W'((num < 0) ? -quo : quo);
            if (count == PIN_W)
            begin
                r.valid_res       = 1'b0;
                r.confidence_code = CONF_NONE;
            end
            else
            begin
                r.valid_res       = 1'b1;
                r.confidence_code = (count == 1) ? CONF_ONE : CONF_MULTI;
            end
            if (r.valid_res && r.position != 0)
                dir_state = (r.position > 0) ? DIR_POS : DIR_NEG;
        end
        else
        begin
            r.valid_res       = 1'b0;
            r.confidence_code = CONF_NONE;
            case (dir_state)
                DIR_POS: r.position = ONE_Q14;
                DIR_NEG: r.position = NEG_ONE_Q14;
                default: r.position = prev_pos_state;
            endcase
        end
        prev_pos_state = r.position;
        r.stamp_out    = stamp;
        return r;
    endfunction

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [PIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_REVERSE:  cur_reverse  = val[0];
            REG_POLARITY: cur_polarity = val[0];
            REG_ASSIGNED: cur_assigned = val;
            default:      ;
        endcase
    endtask

    task automatic send_poll(input logic [PIN_W-1:0] pins, input logic [STAMP_W-1:0] stamp,
                             input logic use_want, input centroid_t want);
        centroid_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        pin_levels  <= pins;
        sample_time <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // beat taken at this edge: advance the predictor in order
        predicted = predict_centroid(pins, stamp);
        centroid_q.push_back(use_want ? want : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (centroid_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        row_t               row;
        centroid_t          want;
        bit                 polls_open;
        bit                 cfg_open;
        int                 r;
        int                 ph;
        int                 n;
        int                 width;
        logic               rev;
        logic               pol;
        logic [PIN_W-1:0]   msk;
        logic [PIN_W-1:0]   pins;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] stamp_base;
        polls_open = 1'b0;
        cfg_open   = 1'b0;
        stamp_base = $urandom;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_COUNT; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE)
            begin
                if (polls_open)
                    drain_results();
                polls_open = 1'b0;
                write_reg(row.reg_idx, row.value);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                    cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                want = '{row.w_pos, row.w_valid, row.w_conf, row.w_act, row.w_lev, row.stamp};
                send_poll(row.value, row.stamp, row.typed, want);
                polls_open = 1'b1;
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:       begin rev = 1'b0; pol = 1'b1; msk = 8'hFF; end
                1:       begin rev = 1'b1; pol = 1'b1; msk = 8'hFF; end
                2:       begin rev = 1'b1; pol = 1'b0; msk = 8'hFF; end
                3:       begin rev = 1'b0; pol = 1'b0; msk = 8'h3F; end
                4:       begin rev = 1'b0; pol = 1'b1; msk = 8'h00; end
                5:       begin rev = 1'b1; pol = 1'b1; msk = 8'h81; end
                8:       begin rev = 1'b0; pol = 1'b1; msk = 8'hFF; end
                default:
                begin
                    rev = 1'($urandom);
                    pol = 1'($urandom);
                    msk = 8'($urandom);
                end
            endcase
            write_reg(REG_REVERSE, {7'b0, rev});
            write_reg(REG_POLARITY, {7'b0, pol});
            write_reg(REG_ASSIGNED, msk);
            cfg_valid <= 1'b0;
            idle_on = (ph != 4) && (ph != NUM_PHASES - 1);
            // hold the output long enough that the block backs up its input
            if (ph == 1)
                hold_off_req = 1'b1;
            for (n = 0; n < PHASE_POLLS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    pins = 8'($urandom);
                    2:       pins = 8'h00;
                    3:       pins = 8'hFF;
                    default:
                    begin
                        // a line one to three sensors wide, in the active sense
                        width = $urandom_range(1, 3);
                        pins  = 8'(((1 << width) - 1) << $urandom_range(0, PIN_W - 1));
                        if (!cur_polarity)
                            pins = ~pins;
                    end
                endcase
                if ($urandom_range(0, 3) == 0)
                    stamp = $urandom;
                else
                begin
                    stamp_base = stamp_base + $urandom_range(1, 5000);
                    stamp      = stamp_base;
                end
                send_poll(pins, stamp, 1'b0, '0);
            end
        end

        drain_results();
        repeat (END_SETTLE_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("tb_line_sensor_position_estimator_top: clean");
        else
            $display("tb_line_sensor_position_estimator_top: errors");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        centroid_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (centroid_q.size() == 0)
                report_mismatch("beat with nothing expected, stamp_out", stamp_out, '0);
            else
            begin
                want = centroid_q.pop_front();
                if (position !== want.position)
                    report_mismatch("position", 32'(position), 32'(want.position));
                if (valid_res !== want.valid_res)
                    report_mismatch("valid_res", 32'(valid_res), 32'(want.valid_res));
                if (confidence_code !== want.confidence_code)
                    report_mismatch("confidence_code", 32'(confidence_code),
                                    32'(want.confidence_code));
                if (active_mask !== want.active_mask)
                    report_mismatch("active_mask", 32'(active_mask), 32'(want.active_mask));
                if (level_mask !== want.level_mask)
                    report_mismatch("level_mask", 32'(level_mask), 32'(want.level_mask));
                if (stamp_out !== want.stamp_out)
                    report_mismatch("stamp_out", stamp_out, want.stamp_out);
            end
        end
    end

endmodule
